### design/pscd_pkg.sv
// ----------------------------------------------------------------------------
// pscd_pkg: shared types and constants for the speed PI loop with derating
// Holds the sequencer states, configuration register map, the configuration
// bundle and the datapath widths used by the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pscd_pkg;

    // Multiplier operand widths: A is a zero-extended 16-bit gain or constant,
    // B is a signed 19-bit operand (error, integral chunk or duty).
    localparam int unsigned MUL_A_W  = 17;
    localparam int unsigned MUL_B_W  = 19;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned CHUNK_W  = 18;
    localparam int unsigned ACC_W    = PROD_W + CHUNK_W;

    // Integral term operand: the integral is limited to +/-2^ISAT_EXP before
    // it is multiplied. Past that point the gain term alone decides the clamp.
    localparam int unsigned ISAT_W   = 2 * CHUNK_W;
    localparam int unsigned ISAT_EXP = 34;

    localparam int unsigned ERR_W    = 17;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned CUR_W    = 12;
    localparam int unsigned FRAC_W   = 8;

    // Derate factor 29491/32768, about 0.9.
    localparam logic [GAIN_W-1:0] DERATE_NUM   = 16'd29491;
    localparam int unsigned       DERATE_SHIFT = 15;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INT_GAIN      = 3'd1,
        CFG_CURRENT_LIMIT = 3'd2,
        CFG_DUTY_CEILING  = 3'd3,
        CFG_DUTY_FLOOR    = 3'd4
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 16'd256;
    localparam logic [GAIN_W-1:0] RST_INT_GAIN      = 16'd26;
    localparam logic [CUR_W-1:0]  RST_CURRENT_LIMIT = 12'd10;
    localparam logic [DUTY_W-1:0] RST_DUTY_CEILING  = 16'd4199;
    localparam logic [DUTY_W-1:0] RST_DUTY_FLOOR    = 16'd0;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] int_gain;
        logic [CUR_W-1:0]  current_limit;
        logic [DUTY_W-1:0] duty_ceiling;
        logic [DUTY_W-1:0] duty_floor;
    } t_cfg;

    // Control bundle from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic acc_clr;
        logic acc_add;
        logic acc_shift;
    } t_mac_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_ACC_LAST,
        ST_CLAMP,
        ST_DERATE,
        ST_DERATE_SHIFT,
        ST_DONE
    } t_state;

endpackage

### design/pscd_in_if.sv
// ----------------------------------------------------------------------------
// pscd_in_if: input channel of the speed PI loop
// Valid/ready channel carrying the speed setpoint, speed and current sample.
// ----------------------------------------------------------------------------
interface pscd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] target_speed;
    logic [15:0] actual_speed;
    logic [11:0] current_sample;

    modport source (
        output valid, target_speed, actual_speed, current_sample,
        input  ready
    );
    modport sink (
        input  valid, target_speed, actual_speed, current_sample,
        output ready
    );
endinterface

### design/pscd_out_if.sv
// ----------------------------------------------------------------------------
// pscd_out_if: result channel of the speed PI loop
// Valid/ready channel carrying the duty value and the status flags.
// ----------------------------------------------------------------------------
interface pscd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty;
    logic        over_current;
    logic        clamped;

    modport source (
        output valid, duty, over_current, clamped,
        input  ready
    );
    modport sink (
        input  valid, duty, over_current, clamped,
        output ready
    );
endinterface

### design/pscd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pscd_cfg_regs: configuration register file
// Five write-only registers, loaded by index from the plain write port.
// ----------------------------------------------------------------------------
module pscd_cfg_regs
    import pscd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= RST_PROP_GAIN;
            r_cfg.int_gain      <= RST_INT_GAIN;
            r_cfg.current_limit <= RST_CURRENT_LIMIT;
            r_cfg.duty_ceiling  <= RST_DUTY_CEILING;
            r_cfg.duty_floor    <= RST_DUTY_FLOOR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_wdata;
                CFG_INT_GAIN:      r_cfg.int_gain      <= i_cfg_wdata;
                CFG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_wdata[CUR_W-1:0];
                CFG_DUTY_CEILING:  r_cfg.duty_ceiling  <= i_cfg_wdata;
                CFG_DUTY_FLOOR:    r_cfg.duty_floor    <= i_cfg_wdata;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/pscd_mac.sv
// ----------------------------------------------------------------------------
// pscd_mac: shared multiply-accumulate unit
// One signed 17x19 multiplier with a registered product, feeding an
// accumulator that adds the product either as is or shifted up one chunk.
// ----------------------------------------------------------------------------
module pscd_mac
    import pscd_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_op_a,
    input  logic signed [MUL_B_W-1:0] i_op_b,
    input  t_mac_ctrl                 i_ctrl,
    output logic signed [PROD_W-1:0]  o_prod,
    output logic signed [ACC_W-1:0]   o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;

    assign prod_ext = ACC_W'(r_prod);
    assign addend   = i_ctrl.acc_shift ? (prod_ext <<< CHUNK_W) : prod_ext;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + addend;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

### design/pi_speed_loop_current_derate_core.sv
// ----------------------------------------------------------------------------
// pi_speed_loop_current_derate_core: speed PI controller with duty clamp
// and overcurrent derating
//
//   channel   dir   width  contents
//   i_item    in    44     target_speed[16], actual_speed[16], current_sample[12]
//   o_result  out   18     duty[16], over_current, clamped
//   i_cfg_*   in    16     prop_gain, int_gain, current_limit, duty_ceiling,
//                          duty_floor (index 0..4)
//
// Each item steps through INTEG, MUL_P, MUL_ILO, MUL_IHI, ACC_LAST and CLAMP
// to DONE, which loads the result register; DERATE and DERATE_SHIFT come in
// before DONE when the current is over its limit, to form and pick up the
// derate product. DONE holds while the output register is full and not taken.
// The steps are set by the single multiplier: it serves the proportional
// term, two chunks of the integral term and the derate product in turn.
// The input is ready only while the sequencer idles. A finished result sits
// in the output register while the next item is taken and worked on.
// Reset (synchronous, active low) clears the integral, the sequencer, the
// output valid bit and loads the register defaults.
// ----------------------------------------------------------------------------
module pi_speed_loop_current_derate_core
    import pscd_pkg::*;
#(
    parameter int unsigned SUM_WIDTH   = 32,
    parameter int unsigned SPEED_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pscd_in_if.sink               i_item,
    pscd_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Speeds arrive as 16-bit fields; keep only the low SPEED_WIDTH bits, at most 16.
    localparam int unsigned EFF_SPEED_W = (SPEED_WIDTH < 16) ? SPEED_WIDTH : 16;
    localparam logic [15:0] SPEED_MASK  = 16'((17'd1 << EFF_SPEED_W) - 17'd1);

    t_cfg      cfg;
    t_state    r_state, n_state;
    t_mac_ctrl mac_ctrl;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;

    logic signed [ERR_W-1:0]     r_err;
    logic                        r_over;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [ISAT_W-1:0]    isat;
    logic [DUTY_W-1:0]           r_duty;
    logic                        r_clamped;

    logic                        r_out_valid;
    logic [DUTY_W-1:0]           r_out_duty;
    logic                        r_out_over;
    logic                        r_out_clamped;

    logic [15:0]             tgt_m, act_m;
    logic signed [ACC_W-1:0] ceil_q, floor_q, pi_mid, pi_fin;
    logic                    hit_ceil, hit_floor;
    logic                    load_out;

    pscd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    pscd_mac u_mac (
        .i_clk (i_clk),
        .i_op_a(op_a),
        .i_op_b(op_b),
        .i_ctrl(mac_ctrl),
        .o_prod(prod),
        .o_acc (acc)
    );

    // ---- error and integral -------------------------------------------
    assign tgt_m = i_item.target_speed & SPEED_MASK;
    assign act_m = i_item.actual_speed & SPEED_MASK;

    // Saturating integral update: overflow shows as differing top two bits.
    assign sum_wide = (SUM_WIDTH + 1)'(r_sum) + (SUM_WIDTH + 1)'(r_err);
    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    // Integral operand for the gain product, limited to +/-2^ISAT_EXP. Beyond
    // that the integral term outweighs any proportional term and the clamp
    // result cannot change.
    generate
        if (SUM_WIDTH <= ISAT_EXP + 1) begin : g_isat_ext
            assign isat = ISAT_W'(r_sum);
        end else begin : g_isat_lim
            localparam logic signed [SUM_WIDTH-1:0] ISAT_HI =
                {{(SUM_WIDTH-ISAT_EXP-1){1'b0}}, 1'b1, {ISAT_EXP{1'b0}}};
            localparam logic signed [SUM_WIDTH-1:0] ISAT_LO = -ISAT_HI;
            always_comb begin
                if (r_sum > ISAT_HI) begin
                    isat = ISAT_W'(ISAT_HI);
                end else if (r_sum < ISAT_LO) begin
                    isat = ISAT_W'(ISAT_LO);
                end else begin
                    isat = r_sum[ISAT_W-1:0];
                end
            end
        end
    endgenerate

    // ---- clamp ----------------------------------------------------------
    // Ceiling first, then floor: with the floor above the ceiling the floor wins.
    assign ceil_q    = ACC_W'({cfg.duty_ceiling, {FRAC_W{1'b0}}});
    assign floor_q   = ACC_W'({cfg.duty_floor, {FRAC_W{1'b0}}});
    assign hit_ceil  = acc > ceil_q;
    assign pi_mid    = hit_ceil ? ceil_q : acc;
    assign hit_floor = pi_mid < floor_q;
    assign pi_fin    = hit_floor ? floor_q : pi_mid;

    // ---- sequencer ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        mac_ctrl          = '0;
        op_a              = MUL_A_W'({1'b0, cfg.int_gain});
        op_b              = MUL_B_W'({1'b0, isat[CHUNK_W-1:0]});
        load_out          = 1'b0;
        i_item.ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_state = ST_INTEG;
                end
            end
            ST_INTEG: begin
                mac_ctrl.acc_clr = 1'b1;
                n_state          = ST_MUL_P;
            end
            ST_MUL_P: begin
                op_a    = MUL_A_W'({1'b0, cfg.prop_gain});
                op_b    = MUL_B_W'(r_err);
                n_state = ST_MUL_ILO;
            end
            ST_MUL_ILO: begin
                // accumulate proportional product; issue low integral chunk
                mac_ctrl.acc_add = 1'b1;
                op_b             = MUL_B_W'({1'b0, isat[CHUNK_W-1:0]});
                n_state          = ST_MUL_IHI;
            end
            ST_MUL_IHI: begin
                // upper chunk carries the sign of the integral
                mac_ctrl.acc_add = 1'b1;
                op_b             = MUL_B_W'($signed(isat[ISAT_W-1:CHUNK_W]));
                n_state          = ST_ACC_LAST;
            end
            ST_ACC_LAST: begin
                mac_ctrl.acc_add   = 1'b1;
                mac_ctrl.acc_shift = 1'b1;
                n_state            = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_state = r_over ? ST_DERATE : ST_DONE;
            end
            ST_DERATE: begin
                op_a    = MUL_A_W'({1'b0, DERATE_NUM});
                op_b    = MUL_B_W'({1'b0, r_duty});
                n_state = ST_DERATE_SHIFT;
            end
            ST_DERATE_SHIFT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- working registers ----------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_state == ST_INTEG) begin
            r_sum <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_item.valid) begin
            r_err  <= ERR_W'({1'b0, tgt_m}) - ERR_W'({1'b0, act_m});
            r_over <= i_item.current_sample > cfg.current_limit;
        end
        if (r_state == ST_CLAMP) begin
            r_duty    <= pi_fin[FRAC_W +: DUTY_W];
            r_clamped <= hit_ceil | hit_floor;
        end else if (r_state == ST_DERATE_SHIFT) begin
            r_duty <= prod[DERATE_SHIFT +: DUTY_W];
        end
    end

    // ---- output register ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_duty    <= r_duty;
            r_out_over    <= r_over;
            r_out_clamped <= r_clamped;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.duty         = r_out_duty;
    assign o_result.over_current = r_out_over;
    assign o_result.clamped      = r_out_clamped;

endmodule
